// ===== hdl/wsht_pkg.sv =====
// shared types and constants for the window stack hit test block
`default_nettype none

package wsht_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CLICK = 1'b1;

   // result field widths
   localparam int ID_OUT_BITS   = 5;
   localparam int RSP_DATA_BITS = 8;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/wsht_ram.sv =====
// generic single write port, single read port ram with registered read data
`default_nettype none

module wsht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/wsht_cmp.sv =====
// rectangle containment test, all edges inclusive
`default_nettype none

module wsht_cmp #(
   parameter int COORD_BITS = 12
) (
   input  wire logic [COORD_BITS-1:0] x_lo,
   input  wire logic [COORD_BITS-1:0] y_lo,
   input  wire logic [COORD_BITS-1:0] x_hi,
   input  wire logic [COORD_BITS-1:0] y_hi,
   input  wire logic [COORD_BITS-1:0] point_x,
   input  wire logic [COORD_BITS-1:0] point_y,
   output logic                       holds
);

   // point inside on both axes; an inverted rectangle never holds
   assign holds = (point_x >= x_lo) && (point_x <= x_hi) &&
                  (point_y >= y_lo) && (point_y <= y_hi);

endmodule

`default_nettype wire

// ===== hdl/window_stack_hit_test.sv =====
// window stack hit test: z-ordered rectangle stack with move-to-front on a click
// sequence: an add is taken in idle with no result; a click scans k entries top-down one per cycle,
// then on a hit below the top moves the m = k - 1 entries above it down one place and places the hit
// entry on top; a click on an empty stack goes straight to done; the result register is loaded in done
// requests: one at a time; after a click the next is taken once the result register is loaded
// reset empties the stack; ram contents are left as they are and never read stale
`default_nettype none

module window_stack_hit_test #(
   parameter int MAX_WINDOWS = 16,
   parameter int COORD_BITS  = 12
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // request channel
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // req_tdata: left, bottom, right, top, point_x, point_y, zero fill
   input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // req_tuser: req_type
   input  wire logic                                     req_tuser,
   // result channel
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // rsp_tdata: hit, window_id, zero fill
   output logic      [wsht_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   localparam int CB  = COORD_BITS;
   localparam int AW  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CW  = $clog2(MAX_WINDOWS + 1);
   localparam int IDW = CW;
   localparam int EW  = IDW + 4*CB;
   localparam int OB  = wsht_pkg::ID_OUT_BITS;

   wsht_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [EW-1:0]  found_ff, found_in;
   logic           hit_ff, hit_in;
   logic [CB-1:0]  px_ff, px_in;
   logic [CB-1:0]  py_ff, py_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_hit_ff, rsp_hit_in;
   logic [OB-1:0]  rsp_id_ff, rsp_id_in;

   logic           req_fire;
   logic           is_click;
   logic           slot_free;
   logic [CW-1:0]  count_dec;
   logic [AW-1:0]  top_idx;
   logic           holds;
   logic           ram_we;
   logic [AW-1:0]  ram_wr_addr;
   logic [EW-1:0]  ram_wr_data;
   logic [AW-1:0]  ram_rd_addr;
   logic [EW-1:0]  ram_rd_data;
   logic [EW-1:0]  new_entry;
   logic [IDW+OB-1:0] id_wide;

   // request fields
   assign req_fire  = req_tvalid && req_tready;
   assign is_click  = (req_tuser == wsht_pkg::REQ_CLICK);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign count_dec = count_ff - 1'b1;
   assign top_idx   = count_dec[AW-1:0];
   assign new_entry = {count_ff + 1'b1, req_tdata[4*CB-1:3*CB], req_tdata[3*CB-1:2*CB],
                       req_tdata[2*CB-1:CB], req_tdata[CB-1:0]};

   // stack storage, entry 0 is the bottom
   wsht_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_WINDOWS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // containment test on the entry just read
   wsht_cmp #(
      .COORD_BITS (CB)
   ) u_cmp (
      .x_lo    (ram_rd_data[CB-1:0]),
      .y_lo    (ram_rd_data[2*CB-1:CB]),
      .x_hi    (ram_rd_data[3*CB-1:2*CB]),
      .y_hi    (ram_rd_data[4*CB-1:3*CB]),
      .point_x (px_ff),
      .point_y (py_ff),
      .holds   (holds)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsht_pkg::ST_IDLE: begin
            if (req_fire && is_click) begin
               state_in = (count_ff == '0) ? wsht_pkg::ST_DONE : wsht_pkg::ST_SCAN;
            end
         end
         wsht_pkg::ST_SCAN: begin
            if (holds) begin
               state_in = (ptr_ff == top_idx) ? wsht_pkg::ST_DONE : wsht_pkg::ST_MOVE;
            end else if (ptr_ff == '0) begin
               state_in = wsht_pkg::ST_DONE;
            end
         end
         wsht_pkg::ST_MOVE: begin
            if (ptr_ff + 1'b1 == top_idx) begin
               state_in = wsht_pkg::ST_PLACE;
            end
         end
         wsht_pkg::ST_PLACE: begin
            state_in = wsht_pkg::ST_DONE;
         end
         wsht_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = wsht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsht_pkg::ST_IDLE;
         end
      endcase
   end

   // ram control and request ready
   always_comb begin
      req_tready  = 1'b0;
      ram_we      = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = new_entry;
      ram_rd_addr = top_idx;
      unique case (state_ff)
         wsht_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            // push on add while room is left
            if (req_fire && !is_click && (count_ff < CW'(MAX_WINDOWS))) begin
               ram_we = 1'b1;
            end
         end
         wsht_pkg::ST_SCAN: begin
            // next entry down on a miss, entry above the hit on a hit
            ram_rd_addr = holds ? ptr_ff + 1'b1 : ptr_ff - 1'b1;
         end
         wsht_pkg::ST_MOVE: begin
            // entry above slides down one place
            ram_we      = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = ram_rd_data;
            ram_rd_addr = ptr_ff + AW'(2);
         end
         wsht_pkg::ST_PLACE: begin
            ram_we      = 1'b1;
            ram_wr_addr = top_idx;
            ram_wr_data = found_ff;
         end
         wsht_pkg::ST_DONE: begin
            ram_we = 1'b0;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      unique case (state_ff)
         wsht_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (is_click) begin
                  px_in  = req_tdata[5*CB-1:4*CB];
                  py_in  = req_tdata[6*CB-1:5*CB];
                  hit_in = 1'b0;
                  ptr_in = top_idx;
               end else if (count_ff < CW'(MAX_WINDOWS)) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         wsht_pkg::ST_SCAN: begin
            if (holds) begin
               hit_in   = 1'b1;
               found_in = ram_rd_data;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         wsht_pkg::ST_MOVE: begin
            ptr_in = ptr_ff + 1'b1;
         end
         wsht_pkg::ST_PLACE: begin
            ptr_in = ptr_ff;
         end
         wsht_pkg::ST_DONE: begin
            ptr_in = ptr_ff;
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   // result register, loaded once the slot is free
   assign id_wide = {{OB{1'b0}}, found_ff[EW-1:4*CB]};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_id_in    = rsp_id_ff;
      if ((state_ff == wsht_pkg::ST_DONE) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_id_in    = hit_ff ? id_wide[OB-1:0] : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsht_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      found_ff   <= found_in;
      hit_ff     <= hit_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_id_ff  <= rsp_id_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wsht_pkg::RSP_DATA_BITS-OB-1){1'b0}}, rsp_id_ff, rsp_hit_ff};

`ifndef SYNTH
   // stack never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_WINDOWS))
      else $error("window count above capacity");

   // an add with room left grows the stack by exactly one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_click && (count_ff < CW'(MAX_WINDOWS)))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("add did not push an entry");

   // shifting only happens strictly below the top entry
   a_move_below_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wsht_pkg::ST_MOVE) |-> (ptr_ff < top_idx))
      else $error("shift pointer reached the top");

   // a reported hit names an existing window
   a_hit_id_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wsht_pkg::ST_DONE) && hit_ff)
      |-> ((found_ff[EW-1:4*CB] != '0) && (found_ff[EW-1:4*CB] <= count_ff)))
      else $error("hit window id out of range");
`endif

endmodule

`default_nettype wire
